>>> rtl/core/tgad_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tgad_pkg;

   // decoder phases, one-hot
   typedef enum logic [4:0] {
      PH_HEADER = 5'b00001,
      PH_IDSKIP = 5'b00010,
      PH_PACKET = 5'b00100,
      PH_DATA   = 5'b01000,
      PH_HALT   = 5'b10000
   } phase_type;

   // result kinds
   localparam logic [1:0] KIND_PIXEL     = 2'd0;
   localparam logic [1:0] KIND_HEADER    = 2'd1;
   localparam logic [1:0] KIND_BAD_DEPTH = 2'd2;
   localparam logic [1:0] KIND_BAD_TYPE  = 2'd3;

   // header byte offsets
   localparam logic [4:0] HDR_ID_LEN    = 5'd0;
   localparam logic [4:0] HDR_TYPE      = 5'd2;
   localparam logic [4:0] HDR_WIDTH_LO  = 5'd12;
   localparam logic [4:0] HDR_WIDTH_HI  = 5'd13;
   localparam logic [4:0] HDR_HEIGHT_LO = 5'd14;
   localparam logic [4:0] HDR_HEIGHT_HI = 5'd15;
   localparam logic [4:0] HDR_DEPTH     = 5'd16;
   localparam logic [4:0] HDR_LAST      = 5'd17;

   localparam logic [7:0] TYPE_RAW     = 8'd2;
   localparam logic [7:0] TYPE_RLE     = 8'd10;
   localparam logic [7:0] DEPTH_24     = 8'd24;
   localparam logic [7:0] DEPTH_32     = 8'd32;
   localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

   typedef struct packed {
      phase_type   phase;
      logic [4:0]  header_index;
      logic [7:0]  id_skip_left;
      logic        is_run_length;
      logic        four_bytes;
      logic [15:0] width;
      logic [15:0] height;
      logic [31:0] pixels_left;
      logic [7:0]  packet_pixels_left;
      logic        packet_is_run;
      logic [1:0]  byte_in_pixel;
      logic [31:0] pixel_assembly;   // type/depth bytes during the header
   } tgad_state_type;

   localparam tgad_state_type STATE_RESET = '{
      phase:              PH_HEADER,
      header_index:       5'd0,
      id_skip_left:       8'd0,
      is_run_length:      1'b0,
      four_bytes:         1'b0,
      width:              16'd0,
      height:             16'd0,
      pixels_left:        32'd0,
      packet_pixels_left: 8'd0,
      packet_is_run:      1'b0,
      byte_in_pixel:      2'd0,
      pixel_assembly:     32'd0
   };

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [7:0]  alpha;
      logic [7:0]  repeat_count;
      logic [15:0] image_width;
      logic [15:0] image_height;
      logic        last_item;
   } tgad_result_type;

endpackage

`default_nettype wire

>>> rtl/core/tgad_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface tgad_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       new_file;

   modport source (output valid, output data_byte, output new_file, input ready);
   modport sink   (input valid, input data_byte, input new_file, output ready);
endinterface

`default_nettype wire

>>> rtl/core/tgad_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface tgad_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [7:0]  red;
   logic [7:0]  green;
   logic [7:0]  blue;
   logic [7:0]  alpha;
   logic [7:0]  repeat_count;
   logic [15:0] image_width;
   logic [15:0] image_height;
   logic        last_item;

   modport source (
      output valid, output kind, output red, output green, output blue, output alpha,
      output repeat_count, output image_width, output image_height, output last_item,
      input ready
   );
   modport sink (
      input valid, input kind, input red, input green, input blue, input alpha,
      input repeat_count, input image_width, input image_height, input last_item,
      output ready
   );
endinterface

`default_nettype wire

>>> rtl/core/tgad_decode_step.sv
`timescale 1ns / 1ps
`default_nettype none

module tgad_decode_step
   import tgad_pkg::*;
(
   input  tgad_state_type  state_cur,
   input  logic [7:0]      data_byte,
   input  logic            new_file,
   output tgad_state_type  state_nxt,
   output tgad_result_type result,
   output logic            fire
);

   tgad_state_type cur;
   logic [31:0]    area;
   logic [7:0]     type_byte;
   logic [7:0]     depth_byte;
   logic [7:0]     run_len;
   logic [31:0]    assembled;
   logic [1:0]     last_pos;
   logic [7:0]     count;
   logic [7:0]     ppl_next;
   logic [31:0]    pixels_next;

   assign cur        = new_file ? STATE_RESET : state_cur;
   assign area       = {16'd0, cur.width} * {16'd0, cur.height};
   assign type_byte  = cur.pixel_assembly[7:0];
   assign depth_byte = cur.pixel_assembly[15:8];
   assign last_pos   = cur.four_bytes ? 2'd3 : 2'd2;

   always_comb begin
      run_len = {1'b0, data_byte[6:0]} + 8'd1;
      if ({24'd0, run_len} > cur.pixels_left) begin
         run_len = cur.pixels_left[7:0];
      end
   end

   always_comb begin
      assembled = cur.pixel_assembly;
      case (cur.byte_in_pixel)
         2'd0:    assembled[7:0]   = cur.pixel_assembly[7:0]   | data_byte;
         2'd1:    assembled[15:8]  = cur.pixel_assembly[15:8]  | data_byte;
         2'd2:    assembled[23:16] = cur.pixel_assembly[23:16] | data_byte;
         default: assembled[31:24] = cur.pixel_assembly[31:24] | data_byte;
      endcase
   end

   // repeat count of the pixel being finished, clamped to what is left
   always_comb begin
      ppl_next = cur.packet_pixels_left;
      count    = 8'd1;
      if (cur.is_run_length) begin
         if (cur.packet_is_run) begin
            count    = cur.packet_pixels_left;
            ppl_next = 8'd0;
         end else if (cur.packet_pixels_left != 8'd0) begin
            ppl_next = cur.packet_pixels_left - 8'd1;
         end
      end
      if (count == 8'd0) begin
         count = 8'd1;
      end
      if ({24'd0, count} > cur.pixels_left) begin
         count = cur.pixels_left[7:0];
      end
      pixels_next = cur.pixels_left - {24'd0, count};
   end

   always_comb begin
      state_nxt = cur;
      result    = '0;
      fire      = 1'b0;
      unique case (cur.phase)
         PH_HEADER: begin
            if (cur.header_index != HDR_LAST) begin
               unique case (cur.header_index)
                  HDR_ID_LEN:    state_nxt.id_skip_left         = data_byte;
                  HDR_TYPE:      state_nxt.pixel_assembly[7:0]  = data_byte;
                  HDR_WIDTH_LO:  state_nxt.width[7:0]           = data_byte;
                  HDR_WIDTH_HI:  state_nxt.width[15:8]          = data_byte;
                  HDR_HEIGHT_LO: state_nxt.height[7:0]          = data_byte;
                  HDR_HEIGHT_HI: state_nxt.height[15:8]         = data_byte;
                  HDR_DEPTH:     state_nxt.pixel_assembly[15:8] = data_byte;
                  default:       ;
               endcase
               state_nxt.header_index = cur.header_index + 5'd1;
            end else begin
               fire                = 1'b1;
               result.image_width  = cur.width;
               result.image_height = cur.height;
               if (depth_byte != DEPTH_24 && depth_byte != DEPTH_32) begin
                  result.kind      = KIND_BAD_DEPTH;
                  result.last_item = 1'b1;
                  state_nxt.phase  = PH_HALT;
               end else if (type_byte != TYPE_RAW && type_byte != TYPE_RLE) begin
                  result.kind      = KIND_BAD_TYPE;
                  result.last_item = 1'b1;
                  state_nxt.phase  = PH_HALT;
               end else begin
                  result.kind                  = KIND_HEADER;
                  state_nxt.four_bytes         = (depth_byte == DEPTH_32);
                  state_nxt.is_run_length      = (type_byte == TYPE_RLE);
                  state_nxt.pixels_left        = area;
                  state_nxt.pixel_assembly     = 32'd0;
                  state_nxt.byte_in_pixel      = 2'd0;
                  state_nxt.packet_pixels_left = 8'd0;
                  state_nxt.packet_is_run      = 1'b0;
                  // empty image iff either dimension is zero
                  if (cur.width == 16'd0 || cur.height == 16'd0) begin
                     result.last_item = 1'b1;
                     state_nxt.phase  = PH_HALT;
                  end else if (cur.id_skip_left != 8'd0) begin
                     state_nxt.phase = PH_IDSKIP;
                  end else begin
                     state_nxt.phase = (type_byte == TYPE_RLE) ? PH_PACKET : PH_DATA;
                  end
               end
            end
         end
         PH_IDSKIP: begin
            state_nxt.id_skip_left = cur.id_skip_left - 8'd1;
            if (cur.id_skip_left == 8'd1) begin
               state_nxt.byte_in_pixel      = 2'd0;
               state_nxt.pixel_assembly     = 32'd0;
               state_nxt.packet_pixels_left = 8'd0;
               state_nxt.packet_is_run      = 1'b0;
               state_nxt.phase = cur.is_run_length ? PH_PACKET : PH_DATA;
            end
         end
         PH_PACKET: begin
            state_nxt.packet_pixels_left = run_len;
            state_nxt.packet_is_run      = data_byte[7];
            state_nxt.byte_in_pixel      = 2'd0;
            state_nxt.pixel_assembly     = 32'd0;
            state_nxt.phase              = PH_DATA;
         end
         PH_DATA: begin
            if (cur.byte_in_pixel != last_pos) begin
               state_nxt.pixel_assembly = assembled;
               state_nxt.byte_in_pixel  = cur.byte_in_pixel + 2'd1;
            end else begin
               fire                         = 1'b1;
               result.kind                  = KIND_PIXEL;
               result.red                   = assembled[23:16];
               result.green                 = assembled[15:8];
               result.blue                  = assembled[7:0];
               result.alpha                 = cur.four_bytes ? assembled[31:24] : ALPHA_OPAQUE;
               result.repeat_count          = count;
               state_nxt.byte_in_pixel      = 2'd0;
               state_nxt.pixel_assembly     = 32'd0;
               state_nxt.packet_pixels_left = ppl_next;
               state_nxt.pixels_left        = pixels_next;
               if (pixels_next == 32'd0) begin
                  result.last_item = 1'b1;
                  state_nxt.phase  = PH_HALT;
               end else if (cur.is_run_length && ppl_next == 8'd0) begin
                  state_nxt.phase = PH_PACKET;
               end
            end
         end
         default: ;   // halted: drop bytes
      endcase
   end

endmodule

`default_nettype wire

>>> rtl/core/tga_rle_pixel_decoder_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel      | Dir | Handshake       | Item
// -------------+-----+-----------------+--------------------------------------------
// req_channel  | in  | valid && ready  | data_byte, new_file
// rsp_channel  | out | valid && ready  | kind, red, green, blue, alpha, repeat_count,
//              |     |                 | image_width, image_height, last_item
//
// One byte per cycle while req ready is high: each item is decoded from the state
// register into the result register; a result appears the cycle after its byte.
// req ready is low only while a result waits and rsp ready is low.
// Synchronous reset puts the decoder in the header phase with no result pending.

module tga_rle_pixel_decoder_core
   import tgad_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   tgad_req_if.sink    req_channel,
   tgad_rsp_if.source  rsp_channel
);

   tgad_state_type  state_ff;
   tgad_state_type  state_in;
   tgad_result_type result_in;
   tgad_result_type rsp_data_ff;
   logic            rsp_valid_ff;
   logic            fire;
   logic            accept;

   tgad_decode_step u_step (
      .state_cur (state_ff),
      .data_byte (req_channel.data_byte),
      .new_file  (req_channel.new_file),
      .state_nxt (state_in),
      .result    (result_in),
      .fire      (fire)
   );

   assign req_channel.ready = !rsp_valid_ff || rsp_channel.ready;
   assign accept            = req_channel.valid && req_channel.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= STATE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         // an accept implies any pending result has just been taken
         if (accept) begin
            state_ff     <= state_in;
            rsp_valid_ff <= fire;
         end else if (rsp_channel.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && fire) begin
         rsp_data_ff <= result_in;
      end
   end

   assign rsp_channel.valid        = rsp_valid_ff;
   assign rsp_channel.kind         = rsp_data_ff.kind;
   assign rsp_channel.red          = rsp_data_ff.red;
   assign rsp_channel.green        = rsp_data_ff.green;
   assign rsp_channel.blue         = rsp_data_ff.blue;
   assign rsp_channel.alpha        = rsp_data_ff.alpha;
   assign rsp_channel.repeat_count = rsp_data_ff.repeat_count;
   assign rsp_channel.image_width  = rsp_data_ff.image_width;
   assign rsp_channel.image_height = rsp_data_ff.image_height;
   assign rsp_channel.last_item    = rsp_data_ff.last_item;

   // a final item always leaves the decoder halted
   a_last_halts: assert property (@(posedge clock) disable iff (reset)
      accept && fire && result_in.last_item |=> state_ff.phase == PH_HALT)
      else $error("final item did not halt the decoder");

   // pixel phases never run with nothing left to decode
   a_pixels_left: assert property (@(posedge clock) disable iff (reset)
      (state_ff.phase == PH_PACKET || state_ff.phase == PH_DATA)
         |-> state_ff.pixels_left != 32'd0)
      else $error("pixel phase with no pixels left");

   // a packet never promises more pixels than the image holds
   a_packet_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff.phase == PH_DATA
         |-> {24'd0, state_ff.packet_pixels_left} <= state_ff.pixels_left)
      else $error("packet overshoots the image");

   // a result is never overwritten before it is taken
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_channel.ready |-> !accept)
      else $error("item accepted over a pending result");

endmodule

`default_nettype wire

>>> verif/tga_rle_pixel_decoder_core_tb.sv
`timescale 1ns / 1ps

module tga_rle_pixel_decoder_core_tb
   import tgad_pkg::*;
;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_ITEMS = 20;   // per idling phase, four phases

   logic clock;
   logic reset;

   tgad_req_if req_ch();
   tgad_rsp_if rsp_ch();

   tga_rle_pixel_decoder_core u_top (
      .clock       (clock),
      .reset       (reset),
      .req_channel (req_ch),
      .rsp_channel (rsp_ch)
   );

   // decoder mirror
   phase_type   dec_phase;
   logic [4:0]  hdr_pos;
   logic [7:0]  id_left;
   logic        rle_mode;
   logic        has_alpha;
   logic [15:0] img_w;
   logic [15:0] img_h;
   logic [31:0] px_remaining;
   logic [7:0]  pkt_left;
   logic        pkt_run;
   logic [1:0]  byte_pos;
   logic [31:0] px_acc;

   tgad_result_type predicted_decodes[$];

   int fault_count    = 0;
   int live_items     = 0;
   int cycle_count    = 0;
   int rx_hold_cycles = 0;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void clear_decoder();
      dec_phase    = PH_HEADER;
      hdr_pos      = '0;
      id_left      = '0;
      rle_mode     = 1'b0;
      has_alpha    = 1'b0;
      img_w        = '0;
      img_h        = '0;
      px_remaining = '0;
      pkt_left     = '0;
      pkt_run      = 1'b0;
      byte_pos     = '0;
      px_acc       = '0;
   endfunction

   function automatic void start_pixel_data();
      byte_pos  = '0;
      px_acc    = '0;
      pkt_left  = '0;
      pkt_run   = 1'b0;
      dec_phase = rle_mode ? PH_PACKET : PH_DATA;
   endfunction

   // returns 1 when the byte yields a result
   function automatic bit predict_decode(input logic [7:0] b, input logic nf,
                                         output tgad_result_type r);
      int          need;
      logic [31:0] count;
      logic [7:0]  img_type;
      logic [7:0]  depth;
      if (nf)
         clear_decoder();
      r = '0;
      case (dec_phase)
         PH_HEADER: begin
            if (hdr_pos < HDR_LAST) begin
               case (hdr_pos)
                  HDR_ID_LEN:    id_left = b;
                  HDR_TYPE:      px_acc[7:0] = b;
                  HDR_WIDTH_LO:  img_w[7:0] = b;
                  HDR_WIDTH_HI:  img_w[15:8] = b;
                  HDR_HEIGHT_LO: img_h[7:0] = b;
                  HDR_HEIGHT_HI: img_h[15:8] = b;
                  HDR_DEPTH:     px_acc[15:8] = b;
                  default: ;
               endcase
               hdr_pos = hdr_pos + 5'd1;
               return 1'b0;
            end
            img_type       = px_acc[7:0];
            depth          = px_acc[15:8];
            r.image_width  = img_w;
            r.image_height = img_h;
            // depth is judged before type
            if (depth != DEPTH_24 && depth != DEPTH_32) begin
               r.kind      = KIND_BAD_DEPTH;
               r.last_item = 1'b1;
               dec_phase   = PH_HALT;
               return 1'b1;
            end
            if (img_type != TYPE_RAW && img_type != TYPE_RLE) begin
               r.kind      = KIND_BAD_TYPE;
               r.last_item = 1'b1;
               dec_phase   = PH_HALT;
               return 1'b1;
            end
            r.kind       = KIND_HEADER;
            has_alpha    = (depth == DEPTH_32);
            rle_mode     = (img_type == TYPE_RLE);
            px_remaining = {16'd0, img_w} * {16'd0, img_h};
            px_acc       = '0;
            byte_pos     = '0;
            if (px_remaining == 0) begin
               r.last_item = 1'b1;
               dec_phase   = PH_HALT;
            end else if (id_left != 0) begin
               dec_phase = PH_IDSKIP;
            end else begin
               start_pixel_data();
            end
            return 1'b1;
         end
         PH_IDSKIP: begin
            id_left = id_left - 8'd1;
            if (id_left == 0)
               start_pixel_data();
            return 1'b0;
         end
         PH_PACKET: begin
            count = {25'd0, b[6:0]} + 32'd1;
            if (count > px_remaining)
               count = px_remaining;
            pkt_left  = count[7:0];
            pkt_run   = b[7];
            byte_pos  = '0;
            px_acc    = '0;
            dec_phase = PH_DATA;
            return 1'b0;
         end
         PH_DATA: begin
            need   = has_alpha ? 4 : 3;
            px_acc = px_acc | ({24'd0, b} << (8 * byte_pos));
            if (int'(byte_pos) + 1 < need) begin
               byte_pos = byte_pos + 2'd1;
               return 1'b0;
            end
            r.red    = px_acc[23:16];
            r.green  = px_acc[15:8];
            r.blue   = px_acc[7:0];
            r.alpha  = has_alpha ? px_acc[31:24] : ALPHA_OPAQUE;
            byte_pos = '0;
            px_acc   = '0;
            count    = 32'd1;
            if (rle_mode && pkt_run) begin
               count    = {24'd0, pkt_left};
               pkt_left = '0;
            end else if (rle_mode && pkt_left != 0) begin
               pkt_left = pkt_left - 8'd1;
            end
            if (count == 0)
               count = 32'd1;
            if (count > px_remaining)
               count = px_remaining;
            px_remaining   = px_remaining - count;
            r.kind         = KIND_PIXEL;
            r.repeat_count = count[7:0];
            if (px_remaining == 0) begin
               r.last_item = 1'b1;
               dec_phase   = PH_HALT;
            end else if (rle_mode && pkt_left == 0) begin
               dec_phase = PH_PACKET;
            end
            return 1'b1;
         end
         default: return 1'b0;   // halted, and any stray phase code
      endcase
   endfunction

   function automatic string show_result(input tgad_result_type r);
      return $sformatf("kind=%0d rgba=%02h%02h%02h%02h count=%0d size=%0dx%0d last=%0b",
                       r.kind, r.red, r.green, r.blue, r.alpha, r.repeat_count,
                       r.image_width, r.image_height, r.last_item);
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic nf);
      tgad_result_type res;
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.data_byte <= b;
      req_ch.new_file  <= nf;
      @(posedge clock);
      while (!req_ch.ready)
         @(posedge clock);
      if (nf || dec_phase != PH_HALT)
         live_items++;
      if (predict_decode(b, nf, res))
         predicted_decodes.push_back(res);
   endtask

   task automatic send_header(input logic nf, input logic [7:0] id_len,
                              input logic [7:0] img_type, input logic [7:0] depth,
                              input logic [15:0] w, input logic [15:0] h);
      logic [7:0] b;
      for (int i = 0; i <= HDR_LAST; i++) begin
         b = 8'($urandom_range(255));
         case (5'(i))
            HDR_ID_LEN:    b = id_len;
            HDR_TYPE:      b = img_type;
            HDR_WIDTH_LO:  b = w[7:0];
            HDR_WIDTH_HI:  b = w[15:8];
            HDR_HEIGHT_LO: b = h[7:0];
            HDR_HEIGHT_HI: b = h[15:8];
            HDR_DEPTH:     b = depth;
            default: ;
         endcase
         send_byte(b, nf && i == 0);
      end
   endtask

   // stored order is B, G, R then A
   task automatic send_pixel(input logic [31:0] argb, input logic four);
      send_byte(argb[7:0], 1'b0);
      send_byte(argb[15:8], 1'b0);
      send_byte(argb[23:16], 1'b0);
      if (four)
         send_byte(argb[31:24], 1'b0);
   endtask

   task automatic send_noise(input int n);
      repeat (n) send_byte(8'($urandom_range(255)), 1'b0);
   endtask

   // sender goes idle until every expected result has come back
   task automatic wait_results_done();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (predicted_decodes.size() != 0)
         @(posedge clock);
   endtask

   task automatic test_raw_without_new_file();
      send_header(1'b0, 8'd0, TYPE_RAW, DEPTH_24, 16'd2, 16'd1);
      send_pixel(32'h0000_0000, 1'b0);
      send_pixel(32'h00FF_FFFF, 1'b0);
      send_noise(1);   // halted: dropped
   endtask

   task automatic test_header_rejects();
      // bad depth and bad type together: depth reported
      send_header(1'b1, 8'd0, 8'd3, 8'd16, 16'hFFFF, 16'hFFFF);
      send_noise(2);
      send_header(1'b1, 8'd0, 8'd1, DEPTH_32, 16'd0, 16'hFFFF);
   endtask

   task automatic test_empty_image();
      send_header(1'b1, 8'd3, TYPE_RLE, DEPTH_32, 16'd0, 16'd7);
      send_noise(2);
   endtask

   task automatic test_rle_packets();
      // run of 128 clamped to a 2x2 image, after an ID field
      send_header(1'b1, 8'd2, TYPE_RLE, DEPTH_32, 16'd2, 16'd2);
      send_noise(2);
      send_byte(8'hFF, 1'b0);
      send_pixel(32'hFF10_2030, 1'b1);
      // literal packet of 128 clamped to 3 pixels, spare bytes dropped
      send_header(1'b1, 8'd0, TYPE_RLE, DEPTH_24, 16'd3, 16'd1);
      send_byte(8'h7F, 1'b0);
      repeat (3) send_pixel($urandom, 1'b0);
      send_noise(3);
      // ordinary mix of runs and literals
      send_header(1'b1, 8'd0, TYPE_RLE, DEPTH_32, 16'd5, 16'd1);
      send_byte(8'h81, 1'b0);
      send_pixel(32'h0000_0000, 1'b1);
      send_byte(8'h01, 1'b0);
      send_pixel(32'hFFFF_FFFF, 1'b1);
      send_pixel($urandom, 1'b1);
      send_byte(8'h80, 1'b0);
      send_pixel($urandom, 1'b1);
   endtask

   task automatic test_long_id_and_restart();
      send_header(1'b1, 8'd255, TYPE_RAW, DEPTH_32, 16'd4, 16'd4);
      send_noise(255);
      repeat (2) send_pixel($urandom, 1'b1);
      send_noise(2);   // half a pixel, then abandoned
      send_byte(8'd0, 1'b1);
      send_noise(4);   // abandoned mid-header
      send_header(1'b1, 8'd4, TYPE_RAW, DEPTH_24, 16'd1, 16'd1);
      send_noise(2);   // abandoned mid-ID
      send_header(1'b1, 8'd0, TYPE_RAW, DEPTH_24, 16'd1, 16'd1);
      send_pixel($urandom, 1'b0);
   endtask

   task automatic test_backpressure();
      rx_hold_cycles = 300;
      send_header(1'b1, 8'd0, TYPE_RAW, DEPTH_24, 16'd3, 16'd2);
      repeat (6) send_pixel($urandom, 1'b0);
      wait_results_done();
   endtask

   task automatic random_file();
      logic [7:0]  id_len;
      logic [7:0]  img_type;
      logic [7:0]  depth;
      logic [7:0]  pkt;
      logic [15:0] w;
      logic [15:0] h;
      logic [31:0] px_left;
      logic        four;
      int          roll;
      int          budget;
      int          n;
      roll     = $urandom_range(99);
      depth    = $urandom_range(1) ? DEPTH_32 : DEPTH_24;
      img_type = $urandom_range(1) ? TYPE_RLE : TYPE_RAW;
      if (roll < 7)
         depth = 8'($urandom_range(255));
      else if (roll < 14)
         img_type = 8'($urandom_range(255));
      id_len = ($urandom_range(99) < 70) ? 8'd0 : 8'($urandom_range(1, 4));
      if ($urandom_range(99) < 8) begin
         w = 16'($urandom_range(65535));
         h = 16'($urandom_range(65535));
      end else begin
         w = ($urandom_range(99) < 5) ? 16'd0 : 16'($urandom_range(1, 4));
         h = 16'($urandom_range(1, 4));
      end
      four = (depth == DEPTH_32);
      send_header($urandom_range(99) < 95, id_len, img_type, depth, w, h);
      if (roll < 14) begin
         send_noise($urandom_range(3));
         return;
      end
      send_noise(int'(id_len));
      px_left = {16'd0, w} * {16'd0, h};
      // a few files are cut short by the next new_file
      budget = ($urandom_range(99) < 10) ? $urandom_range(6) : 24;
      while (px_left != 0 && budget > 0) begin
         if (img_type == TYPE_RLE) begin
            n      = ($urandom_range(99) < 85) ? $urandom_range(1, 4) : $urandom_range(1, 128);
            pkt    = 8'(n - 1);
            pkt[7] = 1'($urandom_range(1));
            send_byte(pkt, 1'b0);
            if (n > px_left)
               n = int'(px_left);
            if (pkt[7]) begin
               send_pixel($urandom, four);
               budget--;
            end else begin
               repeat (n) send_pixel($urandom, four);
               budget -= n;
            end
            px_left = px_left - 32'(n);
         end else begin
            send_pixel($urandom, four);
            px_left = px_left - 32'd1;
            budget--;
         end
      end
      if ($urandom_range(99) < 20)
         send_noise($urandom_range(1, 3));
   endtask

   task automatic run_random_files(input int idle_pct, input int stall_pct);
      int start;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      start          = live_items;
      while (live_items - start < RANDOM_ITEMS)
         random_file();
   endtask

   // result receiver; long hold-offs counted here
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rx_hold_cycles > 0) begin
            rsp_ch.ready <= 1'b0;
            rx_hold_cycles--;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   always @(posedge clock) begin : check_results
      tgad_result_type got;
      tgad_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.kind         = rsp_ch.kind;
         got.red          = rsp_ch.red;
         got.green        = rsp_ch.green;
         got.blue         = rsp_ch.blue;
         got.alpha        = rsp_ch.alpha;
         got.repeat_count = rsp_ch.repeat_count;
         got.image_width  = rsp_ch.image_width;
         got.image_height = rsp_ch.image_height;
         got.last_item    = rsp_ch.last_item;
         if (predicted_decodes.size() == 0) begin
            fault_count++;
            if (fault_count <= 10)
               $display("unexpected item: %s", show_result(got));
         end else begin
            want = predicted_decodes.pop_front();
            if (got !== want) begin
               fault_count++;
               if (fault_count <= 10)
                  $display("mismatch: expected %s, got %s", show_result(want),
                           show_result(got));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tga_rle_pixel_decoder_core_tb: errors");
         $finish;
      end
   end

   initial begin
      reset            <= 1'b1;
      req_ch.valid     <= 1'b0;
      req_ch.data_byte <= 8'd0;
      req_ch.new_file  <= 1'b0;
      clear_decoder();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_raw_without_new_file();
      test_header_rejects();
      test_empty_image();
      test_rle_packets();
      test_long_id_and_restart();
      test_backpressure();
      run_random_files(0, 0);
      run_random_files(66, 0);
      run_random_files(0, 66);
      run_random_files(21, 21);

      recv_stall_pct = 0;
      wait_results_done();
      repeat (10) @(posedge clock);
      fault_count += predicted_decodes.size();
      if (fault_count == 0)
         $display("tga_rle_pixel_decoder_core_tb: clean");
      else
         $display("tga_rle_pixel_decoder_core_tb: errors");
      $finish;
   end

endmodule
